FILE: hdl/sfr_pkg.sv
// Package for the stream find-and-replace unit: default sizes, register
// indexes and the control type shared by the window cells.
// No dependencies.
`default_nettype none

package sfr_pkg;

  localparam int unsigned MaxPatternDef     = 8;
  localparam int unsigned MaxReplacementDef = 8;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgLenW   = 4;

  typedef logic [7:0] byte_t;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_e;

  // Controls broadcast to every window cell.
  typedef struct packed {
    logic advance;  // a request is taken this cycle while the pattern length is not zero
    logic shift;    // full window did not match: move one place to the front
  } cell_ctrl_t;

endpackage : sfr_pkg

`default_nettype wire

FILE: hdl/sfr_stream_if.sv
// Valid/ready stream interfaces for the input and result channels of the
// stream find-and-replace unit. Depends on sfr_pkg.
`default_nettype none

interface sfr_in_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface : sfr_in_if

interface sfr_out_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface : sfr_out_if

`default_nettype wire

FILE: hdl/sfr_cell.sv
// One window cell: holds a single unresolved byte, takes the incoming byte
// when it is the next free place, and compares against its pattern byte.
// Depends on sfr_pkg.
`default_nettype none

module sfr_cell import sfr_pkg::*; (
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  wire        sel_new_i,
  input  byte_t      new_byte_i,
  input  byte_t      nbr_byte_i,
  input  byte_t      pat_byte_i,
  output byte_t      eff_byte_o,
  output logic       eq_o
);

  byte_t byte_q;

  assign eff_byte_o = sel_new_i ? new_byte_i : byte_q;
  assign eq_o       = (eff_byte_o == pat_byte_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      byte_q <= ctrl_i.shift ? nbr_byte_i : eff_byte_o;
    end
  end

endmodule : sfr_cell

`default_nettype wire

FILE: hdl/sfr_drain.sv
// Result drain: a shift chain loaded with all the bytes of one request and
// emptied one byte per accepted result. Depends on sfr_pkg.
`default_nettype none

module sfr_drain import sfr_pkg::*; #(
  parameter int unsigned Depth  = MaxPatternDef,
  parameter int unsigned CountW = $clog2(Depth + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               load_i,
  input  byte_t             load_bytes_i [Depth],
  input  wire  [CountW-1:0] load_count_i,
  input  wire               pop_i,
  output byte_t             head_o,
  output logic [CountW-1:0] count_o
);

  byte_t             slot_q [Depth];
  logic [CountW-1:0] count_q;

  assign head_o  = slot_q[0];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_i) begin
      count_q <= load_count_i;
    end else if (pop_i) begin
      count_q <= count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= load_bytes_i;
    end else if (pop_i) begin
      for (int k = 0; k < Depth - 1; k++) begin
        slot_q[k] <= slot_q[k+1];
      end
      slot_q[Depth-1] <= '0;
    end
  end

endmodule : sfr_drain

`default_nettype wire

FILE: hdl/stream_find_replace_unit.sv
// Top level of the stream find-and-replace unit.
// Depends on sfr_pkg, sfr_stream_if, sfr_cell and sfr_drain.
//
// The unit rewrites a byte stream, replacing every leftmost, non-overlapping
// occurrence of a configured pattern (up to MaxPattern bytes) with a
// configured replacement (up to MaxReplacement bytes). Unresolved bytes sit
// in a row of window cells, one byte per cell, each comparing its byte with
// its pattern byte; when the window is full and every cell agrees, the
// replacement is emitted and the window empties, otherwise the oldest byte
// leaves and the rest move one cell towards the front. A request flagged as
// the final byte flushes the window behind its own results. A pattern length
// of zero passes bytes straight through. All results of one request are
// loaded into a drain chain that hands out one byte per cycle while the
// receiver is ready, with run_last marking the final byte of the group. A
// request yielding at most one byte is taken every cycle while the receiver
// is ready; a larger group holds the input while it drains. A new request
// is taken in the same cycle that the last byte of the previous group is
// taken. Configuration is written through the plain write port while the
// unit is idle; writing the pattern length empties the window.
`default_nettype none

module stream_find_replace_unit import sfr_pkg::*; #(
  parameter int unsigned MaxPattern     = MaxPatternDef,
  parameter int unsigned MaxReplacement = MaxReplacementDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIndexW-1:0] cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  sfr_in_if.sink              in_i,
  sfr_out_if.source           out_o
);

  localparam int unsigned DrainDepth = (MaxPattern > MaxReplacement) ? MaxPattern
                                                                     : MaxReplacement;
  localparam int unsigned FillW  = $clog2(MaxPattern + 1);
  localparam int unsigned RlenW  = $clog2(MaxReplacement + 1);
  localparam int unsigned CountW = $clog2(DrainDepth + 1);

  // Configuration registers.
  logic [CfgDataW-1:0] pat_bytes_q, repl_bytes_q;
  logic [CfgLenW-1:0]  pat_len_q, repl_len_q;

  // Number of bytes currently held in the window.
  logic [FillW-1:0] fill_q, fill_d;

  logic [FillW-1:0] plen, fill_p1;
  logic [RlenW-1:0] rlen;
  logic             accept, pass_through, full, match, shift_win;
  cell_ctrl_t       cell_ctrl;

  byte_t            eff_byte [MaxPattern];
  logic             eq_cell  [MaxPattern];
  logic [MaxPattern-1:0] cell_ok;

  byte_t             load_bytes [DrainDepth];
  logic [CountW-1:0] load_count, drain_count;
  byte_t             drain_head;
  logic              pop;

  // Oversized lengths are clamped to the sizes built.
  assign plen = (pat_len_q > CfgLenW'(MaxPattern)) ? FillW'(MaxPattern) : FillW'(pat_len_q);
  assign rlen = (repl_len_q > CfgLenW'(MaxReplacement)) ? RlenW'(MaxReplacement)
                                                         : RlenW'(repl_len_q);

  // Handshakes: the drain must be empty, or hand out its last byte now.
  assign out_o.valid    = (drain_count != '0);
  assign out_o.out_byte = drain_head;
  assign out_o.run_last = (drain_count == CountW'(1));
  assign pop            = out_o.valid && out_o.ready;
  assign in_i.ready     = (drain_count == '0) || ((drain_count == CountW'(1)) && out_o.ready);
  assign accept         = in_i.valid && in_i.ready;

  assign pass_through = (plen == '0);
  assign fill_p1      = fill_q + FillW'(1);
  assign full         = !pass_through && (fill_p1 == plen);
  assign match        = &cell_ok;
  assign shift_win    = full && !match;

  assign cell_ctrl.advance = accept && !pass_through;
  assign cell_ctrl.shift   = shift_win;

  // Row of window cells; each hands its byte to the cell in front on a shift.
  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    byte_t nbr;
    if (k == MaxPattern - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = eff_byte[k+1];
    end

    sfr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .sel_new_i  (fill_q == FillW'(k)),
      .new_byte_i (in_i.data_byte),
      .nbr_byte_i (nbr),
      .pat_byte_i (pat_bytes_q[8*k +: 8]),
      .eff_byte_o (eff_byte[k]),
      .eq_o       (eq_cell[k])
    );

    // Cells beyond the pattern length take no part in the comparison.
    assign cell_ok[k] = eq_cell[k] || (FillW'(k) >= plen);
  end

  // Result group: the replacement on a match, else the window contents
  // (the oldest byte first, which is the new byte itself in pass-through).
  for (genvar j = 0; j < DrainDepth; j++) begin : g_load
    byte_t win_b, rep_b;
    if (j < MaxPattern) begin : g_win
      assign win_b = eff_byte[j];
    end else begin : g_win_pad
      assign win_b = '0;
    end
    if (j < MaxReplacement) begin : g_rep
      assign rep_b = repl_bytes_q[8*j +: 8];
    end else begin : g_rep_pad
      assign rep_b = '0;
    end
    assign load_bytes[j] = (full && match) ? rep_b : win_b;
  end

  always_comb begin
    priority if (pass_through) begin
      load_count = CountW'(1);
    end else if (full && match) begin
      load_count = CountW'(rlen);
    end else if (full) begin
      load_count = in_i.final_byte ? CountW'(plen) : CountW'(1);
    end else begin
      load_count = in_i.final_byte ? CountW'(fill_p1) : '0;
    end
  end

  always_comb begin
    fill_d = fill_q;
    priority if (cfg_we_i && (cfg_reg_e'(cfg_index_i) == REG_PATTERN_LENGTH)) begin
      fill_d = '0;
    end else if (accept && !pass_through) begin
      priority if ((full && match) || in_i.final_byte) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = fill_q;
      end else begin
        fill_d = fill_p1;
      end
    end else begin
      fill_d = fill_q;
    end
  end

  sfr_drain #(
    .Depth  (DrainDepth),
    .CountW (CountW)
  ) u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .load_bytes_i (load_bytes),
    .load_count_i (load_count),
    .pop_i        (pop),
    .head_o       (drain_head),
    .count_o      (drain_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q  <= '0;
      pat_len_q    <= '0;
      repl_bytes_q <= '0;
      repl_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_BYTES:      pat_bytes_q  <= cfg_data_i;
        REG_PATTERN_LENGTH:     pat_len_q    <= cfg_data_i[CfgLenW-1:0];
        REG_REPLACEMENT_BYTES:  repl_bytes_q <= cfg_data_i;
        REG_REPLACEMENT_LENGTH: repl_len_q   <= cfg_data_i[CfgLenW-1:0];
        default: ;
      endcase
    end
  end

endmodule : stream_find_replace_unit

`default_nettype wire

FILE: bench/sfr_rewrite_board.sv
// Predictor and result checker for the stream find-and-replace bench.
// Depends on sfr_pkg for the byte type, the default sizes and the register indexes.
package sfr_tb_pkg;
  import sfr_pkg::*;

  class sfr_rewrite_board;
    typedef struct packed {
      byte_t out_byte;
      logic  run_last;
    } rewrite_t;

    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rep_bytes;
    logic [3:0]  rep_len;
    byte_t       window [8];
    int unsigned fill;
    rewrite_t    due_q[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned results;
    int unsigned hits;

    function new();
      pat_bytes = '0;
      pat_len   = '0;
      rep_bytes = '0;
      rep_len   = '0;
      foreach (window[i]) window[i] = '0;
      fill     = 0;
      errors   = 0;
      requests = 0;
      results  = 0;
      hits     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_BYTES:      pat_bytes = value;
        REG_PATTERN_LENGTH: begin
          pat_len = value[3:0];
          fill    = 0;
        end
        REG_REPLACEMENT_BYTES:  rep_bytes = value;
        REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Works out the bytes that one accepted request produces.
    function void take_byte(byte_t data, logic last);
      byte_t       group[$];
      int unsigned plen;
      int unsigned rlen;
      logic        hit;
      rewrite_t    item;
      requests++;
      plen = (pat_len > MaxPatternDef) ? MaxPatternDef : pat_len;
      rlen = (rep_len > MaxReplacementDef) ? MaxReplacementDef : rep_len;
      if (plen == 0) begin
        group.push_back(data);
      end else begin
        if (fill >= plen) fill = 0;
        window[fill] = data;
        fill++;
        if (fill == plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++) begin
            if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
          end
          if (hit) begin
            hits++;
            for (int i = 0; i < rlen; i++) group.push_back(rep_bytes[8*i +: 8]);
            fill = 0;
          end else begin
            group.push_back(window[0]);
            for (int i = 0; i < 7; i++) window[i] = window[i+1];
            window[7] = '0;
            fill--;
          end
        end
        if (last) begin
          for (int i = 0; i < fill; i++) group.push_back(window[i]);
          fill = 0;
        end
      end
      foreach (group[i]) begin
        item.out_byte = group[i];
        item.run_last = (i == group.size() - 1);
        due_q.push_back(item);
      end
    endfunction

    function void match_output(byte_t data, logic last);
      rewrite_t due;
      results++;
      if (due_q.size() == 0) begin
        errors++;
        $error("unexpected result: out_byte %02h run_last %0b", data, last);
        return;
      end
      due = due_q.pop_front();
      if (data !== due.out_byte) begin
        errors++;
        $error("out_byte: expected %02h, got %02h", due.out_byte, data);
      end
      if (last !== due.run_last) begin
        errors++;
        $error("run_last: expected %0b, got %0b", due.run_last, last);
      end
    endfunction
  endclass

endpackage : sfr_tb_pkg

FILE: bench/tb_stream_find_replace_unit.sv
// Self-checking bench for stream_find_replace_unit: directed and random byte
// streams under several settings, checked byte by byte against a predictor.
// Depends on sfr_pkg, the stream interfaces, sfr_tb_pkg and the unit itself.
module tb_stream_find_replace_unit;
  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed for the unit to settle once nothing more is expected: a
  // request that yields no byte may still be moving through the window.
  localparam int unsigned SettleCycles = 8;
  // The receiver's one long hold-off, long enough to back the unit up fully.
  localparam int unsigned HoldCycles   = 200;
  // Far above the slowest correct run: every request with eight results,
  // each result waiting out the longest stall, plus the longest input gaps.
  localparam int unsigned LimitCycles  = 500000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  sfr_rewrite_board board;

  bit          no_gaps   = 1'b0;  // both sides run flat out while set
  bit          hold_ask  = 1'b0;  // raised by the sender to ask for the long hold-off
  bit          hold_done = 1'b0;
  byte_t       alpha [3];         // small alphabet that streams draw from
  int unsigned setups    = 0;
  int unsigned cycle_count = 0;

  stream_find_replace_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // One request on the input channel. The valid line is only lowered when a
  // gap follows, so back-to-back requests keep it high without a glitch.
  task automatic send_byte(byte_t data, logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= data;
    in_if.final_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stops offering requests and waits until every expected byte has come out,
  // then lets the unit settle so that it is idle for a register write.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, value);
  endtask

  task automatic load_setup(logic [63:0] pat, logic [3:0] plen,
                            logic [63:0] rep, logic [3:0] rlen);
    write_cfg(REG_PATTERN_BYTES, pat);
    write_cfg(REG_PATTERN_LENGTH, {60'd0, plen});
    write_cfg(REG_REPLACEMENT_BYTES, rep);
    write_cfg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
    setups++;
  endtask

  // A stream built mostly from whole and partial copies of the pattern and
  // from the small alphabet, so that matches, near misses and overlapping
  // candidates turn up often. When closed, the last byte carries the end flag.
  task automatic send_stream(int unsigned len, bit closed);
    byte_t       text[$];
    int unsigned plen;
    int unsigned cut;
    plen = (board.pat_len > MaxPatternDef) ? MaxPatternDef : board.pat_len;
    while (text.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int k = 0; k < plen; k++) text.push_back(board.pat_bytes[8*k +: 8]);
        end
        3, 4: begin
          cut = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
          for (int k = 0; k < cut; k++) text.push_back(board.pat_bytes[8*k +: 8]);
        end
        5, 6, 7: text.push_back(alpha[$urandom_range(0, 2)]);
        default: text.push_back(byte_t'($urandom));
      endcase
    end
    for (int k = 0; k < len; k++) send_byte(text[k], closed && (k == len - 1));
  endtask

  // Free noise: any byte, with the end flag set now and then.
  task automatic send_noise(int unsigned n);
    repeat (n) send_byte(byte_t'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // Both channels are watched from one process, so a request is always
  // noted before any byte that it causes is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        board.take_byte(in_if.data_byte, in_if.final_byte);
      end
      if (out_if.valid && out_if.ready) begin
        board.match_output(out_if.out_byte, out_if.run_last);
      end
    end
  end

  // Receiver: random stalls, none while no_gaps is set, and once a long
  // hold-off counted here while the sender keeps pushing requests in.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_ask && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("Run stopped by the watchdog after %0d cycles", cycle_count);
      $display("FAIL stream_find_replace_unit");
      $finish;
    end
  end

  initial begin
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int unsigned sent;
    int unsigned len;
    bit          closed;
    board            = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.final_byte = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pass-through straight after reset: extreme bytes, and the end flag
    // must change nothing.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);

    // Two-byte pattern with a three-byte replacement: a miss, two matches in
    // a row, and a half-filled window flushed by the end flag.
    settle();
    load_setup(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);

    // Empty replacement: a match vanishes and yields no byte at all.
    settle();
    write_cfg(REG_REPLACEMENT_LENGTH, 64'd0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);

    // Oversized lengths are taken as eight: eight 0xFF bytes become eight
    // zero bytes, the largest group one request can produce.
    settle();
    load_setup('1, 4'd15, 64'd0, 4'd15);
    repeat (8) send_byte(8'hFF, 1'b0);

    // Rewriting the pattern length mid-stream drops the bytes held in the
    // window, so only the last byte comes back at the end of the stream.
    settle();
    write_cfg(REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();
    write_cfg(REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'hFF, 1'b1);

    // Random part: ten settings, the first five pinned to the corners.
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      no_gaps = (phase == 4 || phase == 7);
      foreach (alpha[k]) alpha[k] = byte_t'($urandom);
      pat = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < 8; k++) pat[8*k +: 8] = alpha[$urandom_range(0, 2)];
      end
      case (phase)
        0: begin
          plen = 4'd8;
          rlen = 4'd8;
        end
        1: begin
          plen = 4'd15;
          rlen = 4'd15;
        end
        2: begin
          plen = 4'd0;
          rlen = 4'($urandom_range(0, 15));
        end
        3: begin
          // All-zero pattern over a stream that is nearly all zero.
          pat      = '0;
          alpha[0] = 8'h00;
          alpha[1] = 8'h00;
          alpha[2] = 8'h01;
          plen     = 4'd8;
          rlen     = 4'd1;
        end
        4: begin
          plen = 4'd1;
          rlen = 4'd0;
        end
        default: begin
          plen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
          rlen = 4'($urandom_range(0, 15));
        end
      endcase
      rep = (phase == 5) ? '1 : {$urandom, $urandom};
      load_setup(pat, plen, rep, rlen);
      // With long replacements the drain backs up quickly, so this is where
      // the receiver's long hold-off makes the unit stall its input.
      if (phase == 0) hold_ask = 1'b1;
      sent = 0;
      while (sent < 18) begin
        len    = $urandom_range(2, 12);
        closed = ($urandom_range(0, 3) != 0);
        send_stream(len, closed);
        sent += len;
        // An unfinished stream is sometimes cut short by a pattern length
        // write, which throws the window away.
        if (!closed && $urandom_range(0, 1) == 0) begin
          settle();
          write_cfg(REG_PATTERN_LENGTH, {60'd0, plen});
        end
      end
      send_noise(3);
    end

    settle();
    $display("Checked %0d output bytes from %0d input bytes, %0d pattern hits.",
             board.results, board.requests, board.hits);
    $display("Covered %0d settings incl. pass-through, deletion and oversized lengths.",
             setups);
    if (board.errors == 0) begin
      $display("PASS stream_find_replace_unit");
    end else begin
      $display("FAIL stream_find_replace_unit");
    end
    $finish;
  end

endmodule : tb_stream_find_replace_unit

FILE: sim.f
hdl/sfr_pkg.sv
hdl/sfr_stream_if.sv
hdl/sfr_cell.sv
hdl/sfr_drain.sv
hdl/stream_find_replace_unit.sv
bench/sfr_rewrite_board.sv
bench/tb_stream_find_replace_unit.sv
